@@ hdl/hkrt_pkg.sv @@
// ----------------------------------------------------------------------------
// Keyboard report tracker package
// Operation codes, keycode form bytes and the status passed between the
// update logic and the top level.
// ----------------------------------------------------------------------------
package hkrt_pkg;

    localparam int KEY_SLOTS_DEFAULT = 6;
    localparam int REPORT_SLOTS      = 6;

    typedef enum logic [2:0] {
        OP_PRESS        = 3'd0,
        OP_RELEASE      = 3'd1,
        OP_RELEASE_ALL  = 3'd2,
        OP_TAP          = 3'd3,
        OP_PRESS_CODE   = 3'd4,
        OP_RELEASE_CODE = 3'd5
    } op_t;

    localparam logic [7:0] FORM_MOD_A = 8'h80;
    localparam logic [7:0] FORM_MOD_B = 8'hE0;
    localparam logic [7:0] FORM_KEY_A = 8'h40;
    localparam logic [7:0] FORM_KEY_B = 8'hF0;

    typedef struct packed {
        logic report;
        logic tap;
    } core_status_t;

endpackage

@@ hdl/hid_keyboard_report_tracker.sv @@
// ----------------------------------------------------------------------------
// USB boot keyboard report tracker
// Holds the modifier byte and key slots of a boot keyboard and sends a
// report whenever a request changes them; a tap sends two reports.
// ----------------------------------------------------------------------------
// A request is registered, then its first report is loaded into the output
// register once the update stage fires, which can stall behind a held report.
// Throughput: one request per cycle while the receiver keeps up; a tap holds
// the update stage until the first of its two reports leaves the output register.
// Reset clears the modifier byte, all key slots and every valid flag.
module hid_keyboard_report_tracker
    import hkrt_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [2:0]  operation,
    input  logic [7:0]  key_usage,
    input  logic [7:0]  modifier_bits,
    input  logic [15:0] raw_code,
    output logic        report_valid,
    input  logic        report_ready,
    output logic [7:0]  report_modifiers,
    output logic [7:0]  report_slot0,
    output logic [7:0]  report_slot1,
    output logic [7:0]  report_slot2,
    output logic [7:0]  report_slot3,
    output logic [7:0]  report_slot4,
    output logic [7:0]  report_slot5,
    output logic        last_report
);

    logic         cmd_valid_reg;
    logic [2:0]   operation_reg;
    logic [7:0]   key_usage_reg;
    logic [7:0]   modifier_bits_reg;
    logic [15:0]  raw_code_reg;

    logic [7:0]   held_reg;
    logic [7:0]   held_next;
    logic [7:0]   slots_reg  [KEY_SLOTS];
    logic [7:0]   slots_next [KEY_SLOTS];

    logic [7:0]   core_held;
    logic [7:0]   core_slots [KEY_SLOTS];
    logic [7:0]   rep_held;
    logic [7:0]   rep_slots  [KEY_SLOTS];
    core_status_t status;

    logic [7:0]   rep_view   [REPORT_SLOTS];
    logic [7:0]   state_view [REPORT_SLOTS];

    logic         out_valid_reg;
    logic         out_valid_next;
    logic         out_last_reg;
    logic         out_last_next;
    logic [7:0]   out_mods_reg;
    logic [7:0]   out_mods_next;
    logic [7:0]   out_slots_reg  [REPORT_SLOTS];
    logic [7:0]   out_slots_next [REPORT_SLOTS];
    logic         pend_reg;
    logic         pend_next;

    logic         fire;
    logic         out_take;

    hkrt_core #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_core (
        .operation     (operation_reg),
        .key_usage     (key_usage_reg),
        .modifier_bits (modifier_bits_reg),
        .raw_code      (raw_code_reg),
        .held          (held_reg),
        .slots         (slots_reg),
        .next_held     (core_held),
        .next_slots    (core_slots),
        .rep_held      (rep_held),
        .rep_slots     (rep_slots),
        .status        (status)
    );

    genvar g;
    generate
        for (g = 0; g < REPORT_SLOTS; g++)
        begin : g_view
            if (g < KEY_SLOTS)
            begin : g_live
                assign rep_view[g]   = rep_slots[g];
                assign state_view[g] = slots_reg[g];
            end
            else
            begin : g_zero
                assign rep_view[g]   = 8'd0;
                assign state_view[g] = 8'd0;
            end
        end
    endgenerate

    assign out_take  = out_valid_reg && report_ready;
    assign fire      = cmd_valid_reg && !pend_reg && (!out_valid_reg || report_ready);
    assign cmd_ready = !cmd_valid_reg || fire;

    always_comb
    begin
        held_next      = held_reg;
        slots_next     = slots_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_mods_next  = out_mods_reg;
        out_slots_next = out_slots_reg;
        pend_next      = pend_reg;
        if (fire)
        begin
            held_next  = core_held;
            slots_next = core_slots;
        end
        priority if (fire && status.report)
        begin
            out_valid_next = 1'b1;
            out_last_next  = !status.tap;
            out_mods_next  = rep_held;
            out_slots_next = rep_view;
            pend_next      = status.tap;
        end
        else if (pend_reg && out_take)
        begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b1;
            out_mods_next  = held_reg;
            out_slots_next = state_view;
            pend_next      = 1'b0;
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            held_reg      <= 8'd0;
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                slots_reg[i] <= 8'd0;
            end
        end
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                cmd_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                cmd_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            held_reg      <= held_next;
            slots_reg     <= slots_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            operation_reg     <= operation;
            key_usage_reg     <= key_usage;
            modifier_bits_reg <= modifier_bits;
            raw_code_reg      <= raw_code;
        end
        out_last_reg  <= out_last_next;
        out_mods_reg  <= out_mods_next;
        out_slots_reg <= out_slots_next;
    end

    assign report_valid     = out_valid_reg;
    assign report_modifiers = out_mods_reg;
    assign report_slot0     = out_slots_reg[0];
    assign report_slot1     = out_slots_reg[1];
    assign report_slot2     = out_slots_reg[2];
    assign report_slot3     = out_slots_reg[3];
    assign report_slot4     = out_slots_reg[4];
    assign report_slot5     = out_slots_reg[5];
    assign last_report      = out_last_reg;

    // The second tap report is pending exactly while the first one is shown.
    a_pend_first: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == (out_valid_reg && !out_last_reg))
        else $error("tap pending flag out of step with shown report");

    a_tap_pend: assert property (@(posedge clk) disable iff (!rst_n)
        fire && status.tap |=> pend_reg && out_valid_reg)
        else $error("tap did not leave its second report pending");

    a_second: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && out_take |=> out_valid_reg && out_last_reg && !pend_reg)
        else $error("second tap report not shown after the first");

    a_no_fire_pend: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |=> $stable(held_reg))
        else $error("state changed while a tap report was pending");

endmodule

@@ hdl/hkrt_core.sv @@
// ----------------------------------------------------------------------------
// Keyboard report update logic
// Works out the next modifier byte and key slots for one request, the report
// contents to send first, and whether a report goes out at all.
// ----------------------------------------------------------------------------
module hkrt_core
    import hkrt_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEFAULT
)
(
    input  logic [2:0]   operation,
    input  logic [7:0]   key_usage,
    input  logic [7:0]   modifier_bits,
    input  logic [15:0]  raw_code,
    input  logic [7:0]   held,
    input  logic [7:0]   slots      [KEY_SLOTS],
    output logic [7:0]   next_held,
    output logic [7:0]   next_slots [KEY_SLOTS],
    output logic [7:0]   rep_held,
    output logic [7:0]   rep_slots  [KEY_SLOTS],
    output core_status_t status
);

    logic [7:0] code_hi;
    logic [7:0] code_lo;
    logic       code_mod;
    logic       code_key;
    logic       use_code;
    logic [7:0] eff_key;
    logic [7:0] eff_mods;
    logic       found;
    logic       placed;
    logic       press_chg;
    logic       release_chg;
    logic       any_set;
    logic [7:0] press_slots   [KEY_SLOTS];
    logic [7:0] release_slots [KEY_SLOTS];

    assign code_hi  = raw_code[15:8];
    assign code_lo  = raw_code[7:0];
    assign code_mod = (code_hi == FORM_MOD_A) || (code_hi == FORM_MOD_B);
    assign code_key = (code_hi == FORM_KEY_A) || (code_hi == FORM_KEY_B);
    assign use_code = (operation == OP_PRESS_CODE) || (operation == OP_RELEASE_CODE);

    always_comb
    begin
        if (use_code)
        begin
            eff_key  = code_key ? code_lo : 8'd0;
            eff_mods = code_mod ? code_lo : 8'd0;
        end
        else
        begin
            eff_key  = key_usage;
            eff_mods = modifier_bits;
        end
    end

    always_comb
    begin
        found       = 1'b0;
        placed      = 1'b0;
        release_chg = (eff_mods != 8'd0) && ((held & eff_mods) != 8'd0);
        any_set     = (held != 8'd0);
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if (slots[i] == eff_key)
            begin
                found = 1'b1;
            end
            if (slots[i] != 8'd0)
            begin
                any_set = 1'b1;
            end
        end
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            press_slots[i]   = slots[i];
            release_slots[i] = slots[i];
            if ((eff_key != 8'd0) && !found && !placed && (slots[i] == 8'd0))
            begin
                press_slots[i] = eff_key;
                placed         = 1'b1;
            end
            if ((eff_key != 8'd0) && (slots[i] == eff_key))
            begin
                release_slots[i] = 8'd0;
                release_chg      = 1'b1;
            end
        end
        press_chg = ((eff_mods != 8'd0) && ((held & eff_mods) != eff_mods)) || placed;
    end

    always_comb
    begin
        next_held     = held;
        next_slots    = slots;
        rep_held      = held;
        rep_slots     = slots;
        status.report = 1'b0;
        status.tap    = 1'b0;
        unique case (op_t'(operation))
            OP_PRESS, OP_PRESS_CODE:
            begin
                if (!use_code || code_mod || code_key)
                begin
                    next_held     = held | eff_mods;
                    next_slots    = press_slots;
                    status.report = press_chg;
                end
            end
            OP_RELEASE, OP_RELEASE_CODE:
            begin
                if (!use_code || code_mod || code_key)
                begin
                    next_held     = held & ~eff_mods;
                    next_slots    = release_slots;
                    status.report = release_chg;
                end
            end
            OP_RELEASE_ALL:
            begin
                next_held = 8'd0;
                for (int i = 0; i < KEY_SLOTS; i++)
                begin
                    next_slots[i] = 8'd0;
                end
                status.report = any_set;
            end
            OP_TAP:
            begin
                rep_held      = modifier_bits;
                rep_slots[0]  = key_usage;
                next_held     = 8'd0;
                next_slots[0] = 8'd0;
                status.report = 1'b1;
                status.tap    = 1'b1;
            end
            default:
            begin
                next_held = held;
            end
        endcase
        if (!status.tap)
        begin
            rep_held  = next_held;
            rep_slots = next_slots;
        end
    end

endmodule

@@ tb/sv/hkrt_report_scoreboard.sv @@
// ----------------------------------------------------------------------------
// Keyboard report scoreboard
// Watches the request and report channels of the keyboard report tracker,
// keeps its own copy of the modifier byte and key slots, works out the boot
// reports that each accepted request should cause and compares every
// accepted report with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module hkrt_report_scoreboard
    import hkrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  logic        cmd_ready,
    input  logic [2:0]  operation,
    input  logic [7:0]  key_usage,
    input  logic [7:0]  modifier_bits,
    input  logic [15:0] raw_code,
    input  logic        report_valid,
    input  logic        report_ready,
    input  logic [7:0]  report_modifiers,
    input  logic [7:0]  report_slot0,
    input  logic [7:0]  report_slot1,
    input  logic [7:0]  report_slot2,
    input  logic [7:0]  report_slot3,
    input  logic [7:0]  report_slot4,
    input  logic [7:0]  report_slot5,
    input  logic        last_report,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [7:0]                     mods;
        logic [REPORT_SLOTS-1:0][7:0]   slots;
        logic                           last;
    } boot_report_t;

    logic [7:0]   held_mods;
    logic [7:0]   slot_state [KEY_SLOTS_DEFAULT];
    boot_report_t expected_reports [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic boot_report_t snapshot(input logic last);
        boot_report_t r;
        r.mods = held_mods;
        for (int i = 0; i < REPORT_SLOTS; i++)
        begin
            r.slots[i] = (i < KEY_SLOTS_DEFAULT) ? slot_state[i] : 8'h00;
        end
        r.last = last;
        return r;
    endfunction

    function automatic bit apply_press(input logic [7:0] key, input logic [7:0] mods);
        bit changed;
        changed = 1'b0;
        if (mods != 8'h00 && (held_mods & mods) != mods)
        begin
            held_mods = held_mods | mods;
            changed   = 1'b1;
        end
        if (key != 8'h00)
        begin
            for (int i = 0; i < KEY_SLOTS_DEFAULT; i++)
            begin
                if (slot_state[i] == key)
                    return changed;
            end
            for (int i = 0; i < KEY_SLOTS_DEFAULT; i++)
            begin
                if (slot_state[i] == 8'h00)
                begin
                    slot_state[i] = key;
                    return 1'b1;
                end
            end
        end
        return changed;
    endfunction

    function automatic bit apply_release(input logic [7:0] key, input logic [7:0] mods);
        bit changed;
        changed = 1'b0;
        if (mods != 8'h00 && (held_mods & mods) != 8'h00)
        begin
            held_mods = held_mods & ~mods;
            changed   = 1'b1;
        end
        if (key != 8'h00)
        begin
            for (int i = 0; i < KEY_SLOTS_DEFAULT; i++)
            begin
                if (slot_state[i] == key)
                begin
                    slot_state[i] = 8'h00;
                    changed       = 1'b1;
                end
            end
        end
        return changed;
    endfunction

    function automatic bit decode_code(input logic [15:0] code, output logic [7:0] key,
                                       output logic [7:0] mods);
        key  = 8'h00;
        mods = 8'h00;
        if (code[15:8] == FORM_MOD_A || code[15:8] == FORM_MOD_B)
        begin
            mods = code[7:0];
            return 1'b1;
        end
        if (code[15:8] == FORM_KEY_A || code[15:8] == FORM_KEY_B)
        begin
            key = code[7:0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_request(input logic [2:0] op, input logic [7:0] key,
                                   input logic [7:0] mods, input logic [15:0] code);
        logic [7:0] dec_key;
        logic [7:0] dec_mods;
        logic [7:0] nonzero;
        case (op)
            OP_PRESS:
                if (apply_press(key, mods))
                    expected_reports.push_back(snapshot(1'b1));
            OP_RELEASE:
                if (apply_release(key, mods))
                    expected_reports.push_back(snapshot(1'b1));
            OP_RELEASE_ALL:
            begin
                nonzero   = held_mods;
                held_mods = 8'h00;
                for (int i = 0; i < KEY_SLOTS_DEFAULT; i++)
                begin
                    nonzero       = nonzero | slot_state[i];
                    slot_state[i] = 8'h00;
                end
                if (nonzero != 8'h00)
                    expected_reports.push_back(snapshot(1'b1));
            end
            OP_TAP:
            begin
                held_mods     = mods;
                slot_state[0] = key;
                expected_reports.push_back(snapshot(1'b0));
                held_mods     = 8'h00;
                slot_state[0] = 8'h00;
                expected_reports.push_back(snapshot(1'b1));
            end
            OP_PRESS_CODE:
                if (decode_code(code, dec_key, dec_mods))
                begin
                    if (apply_press(dec_key, dec_mods))
                        expected_reports.push_back(snapshot(1'b1));
                end
            OP_RELEASE_CODE:
                if (decode_code(code, dec_key, dec_mods))
                begin
                    if (apply_release(dec_key, dec_mods))
                        expected_reports.push_back(snapshot(1'b1));
                end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_report();
        boot_report_t want;
        logic [7:0]   got_slots [REPORT_SLOTS];
        if (expected_reports.size() == 0)
        begin
            report_mismatch("report received with no request outstanding");
            return;
        end
        want      = expected_reports.pop_front();
        got_slots = '{report_slot0, report_slot1, report_slot2,
                      report_slot3, report_slot4, report_slot5};
        if (report_modifiers !== want.mods)
            report_mismatch($sformatf("report_modifiers expected %02h, got %02h",
                                      want.mods, report_modifiers));
        for (int i = 0; i < REPORT_SLOTS; i++)
        begin
            if (got_slots[i] !== want.slots[i])
                report_mismatch($sformatf("report_slot%0d expected %02h, got %02h",
                                          i, want.slots[i], got_slots[i]));
        end
        if (last_report !== want.last)
            report_mismatch($sformatf("last_report expected %0b, got %0b",
                                      want.last, last_report));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_mods = 8'h00;
            for (int i = 0; i < KEY_SLOTS_DEFAULT; i++)
            begin
                slot_state[i] = 8'h00;
            end
            expected_reports.delete();
            pending <= 0;
        end
        else
        begin
            if (report_valid && report_ready)
                check_report();
            if (cmd_valid && cmd_ready)
                predict_request(operation, key_usage, modifier_bits, raw_code);
            pending <= expected_reports.size();
        end
    end

endmodule

@@ tb/sv/tb_hid_keyboard_report_tracker.sv @@
// ----------------------------------------------------------------------------
// Keyboard report tracker testbench
// Drives directed and random keyboard requests into the tracker under
// several patterns of sender gaps and receiver stalls, including a long
// receiver hold-off, and lets the scoreboard check every boot report.
// ----------------------------------------------------------------------------
module tb_hid_keyboard_report_tracker;
    import hkrt_pkg::*;

    localparam int         CLK_HALF       = 6;
    localparam int         RESET_CYCLES   = 3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         HOLD_CYCLES    = 200;
    localparam int         DRAIN_CYCLES   = 8;
    localparam logic [2:0] OP_SPARE_6     = 3'd6;
    localparam logic [2:0] OP_SPARE_7     = 3'd7;
    localparam logic [7:0] UTF8_LEAD_LO   = 8'hC2;
    localparam logic [7:0] UTF8_LEAD_HI   = 8'hDF;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_ready;
    logic [2:0]  operation;
    logic [7:0]  key_usage;
    logic [7:0]  modifier_bits;
    logic [15:0] raw_code;
    logic        report_valid;
    logic        report_ready;
    logic [7:0]  report_modifiers;
    logic [7:0]  report_slot0;
    logic [7:0]  report_slot1;
    logic [7:0]  report_slot2;
    logic [7:0]  report_slot3;
    logic [7:0]  report_slot4;
    logic [7:0]  report_slot5;
    logic        last_report;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;
    bit hold_request;

    always #(CLK_HALF) clk = ~clk;

    hid_keyboard_report_tracker uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (cmd_valid),
        .cmd_ready        (cmd_ready),
        .operation        (operation),
        .key_usage        (key_usage),
        .modifier_bits    (modifier_bits),
        .raw_code         (raw_code),
        .report_valid     (report_valid),
        .report_ready     (report_ready),
        .report_modifiers (report_modifiers),
        .report_slot0     (report_slot0),
        .report_slot1     (report_slot1),
        .report_slot2     (report_slot2),
        .report_slot3     (report_slot3),
        .report_slot4     (report_slot4),
        .report_slot5     (report_slot5),
        .last_report      (last_report)
    );

    hkrt_report_scoreboard report_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (cmd_valid),
        .cmd_ready        (cmd_ready),
        .operation        (operation),
        .key_usage        (key_usage),
        .modifier_bits    (modifier_bits),
        .raw_code         (raw_code),
        .report_valid     (report_valid),
        .report_ready     (report_ready),
        .report_modifiers (report_modifiers),
        .report_slot0     (report_slot0),
        .report_slot1     (report_slot1),
        .report_slot2     (report_slot2),
        .report_slot3     (report_slot3),
        .report_slot4     (report_slot4),
        .report_slot5     (report_slot5),
        .last_report      (last_report),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    // The receiver either stalls at random or, when asked, holds off for a long stretch.
    initial
    begin
        report_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                report_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                report_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (report_valid && report_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_hid_keyboard_report_tracker failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [7:0] pick_key();
        int p;
        p = $urandom_range(99);
        if (p < 70)
            return 8'h04 + 8'($urandom_range(9));
        if (p < 80)
            return 8'h00;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_mods();
        int p;
        p = $urandom_range(99);
        if (p < 25)
            return 8'h00;
        if (p < 65)
            return 8'h01 << $urandom_range(7);
        return 8'($urandom_range(255));
    endfunction

    task automatic send_request(input logic [2:0] op, input logic [7:0] key,
                                input logic [7:0] mods, input logic [15:0] code);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid     <= 1'b1;
        operation     <= op;
        key_usage     <= key;
        modifier_bits <= mods;
        raw_code      <= code;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
    endtask

    task automatic wait_for_reports();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic send_random_request(output bit counted);
        int          p;
        logic [2:0]  op;
        logic [15:0] code;
        p = $urandom_range(99);
        if (p < 30)
            op = OP_PRESS;
        else if (p < 55)
            op = OP_RELEASE;
        else if (p < 60)
            op = OP_RELEASE_ALL;
        else if (p < 68)
            op = OP_TAP;
        else if (p < 82)
            op = OP_PRESS_CODE;
        else if (p < 96)
            op = OP_RELEASE_CODE;
        else if (p < 98)
            op = OP_SPARE_6;
        else
            op = OP_SPARE_7;
        p = $urandom_range(99);
        if (p < 40)
            code = {($urandom_range(1) != 0) ? FORM_KEY_A : FORM_KEY_B, pick_key()};
        else if (p < 75)
            code = {($urandom_range(1) != 0) ? FORM_MOD_A : FORM_MOD_B, pick_mods()};
        else if (p < 85)
            code = {8'($urandom_range(UTF8_LEAD_LO, UTF8_LEAD_HI)), 8'($urandom_range(255))};
        else
            code = 16'($urandom_range(65535));
        send_request(op, pick_key(), pick_mods(), code);
        counted = (op != OP_SPARE_6 && op != OP_SPARE_7);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        int sent;
        bit counted;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < count)
        begin
            send_random_request(counted);
            if (counted)
                sent++;
        end
        wait_for_reports();
    endtask

    initial
    begin
        bit counted;
        rst_n          = 1'b0;
        cmd_valid      = 1'b0;
        operation      = OP_PRESS;
        key_usage      = 8'h00;
        modifier_bits  = 8'h00;
        raw_code       = 16'h0000;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every slot, try duplicates and a full table, then work through each form.
        send_request(OP_PRESS, 8'h04, 8'h01, 16'h0000);
        send_request(OP_PRESS, 8'h04, 8'h01, 16'h0000);
        for (int k = 5; k < 10; k++)
        begin
            send_request(OP_PRESS, 8'(k), 8'h00, 16'h0000);
        end
        send_request(OP_PRESS, 8'h0A, 8'h00, 16'h0000);
        send_request(OP_PRESS, 8'h0A, 8'h02, 16'h0000);
        send_request(OP_RELEASE, 8'h06, 8'h00, 16'h0000);
        send_request(OP_PRESS, 8'hFF, 8'h80, 16'h0000);
        send_request(OP_RELEASE, 8'h00, 8'h00, 16'h0000);
        send_request(OP_RELEASE, 8'h00, 8'hFF, 16'h0000);
        send_request(OP_TAP, 8'hFF, 8'hFF, 16'h0000);
        send_request(OP_TAP, 8'h00, 8'h00, 16'h0000);
        send_request(OP_PRESS_CODE, 8'h00, 8'h00, 16'h80A5);
        send_request(OP_PRESS_CODE, 8'h00, 8'h00, 16'hE05A);
        send_request(OP_PRESS_CODE, 8'h00, 8'h00, 16'h402C);
        send_request(OP_PRESS_CODE, 8'h00, 8'h00, 16'hF000);
        send_request(OP_PRESS_CODE, 8'h00, 8'h00, 16'hC241);
        send_request(OP_RELEASE_CODE, 8'h00, 8'h00, 16'hDF04);
        send_request(OP_PRESS_CODE, 8'hFF, 8'hFF, 16'hFFFF);
        send_request(OP_RELEASE_CODE, 8'h00, 8'h00, 16'h0000);
        send_request(OP_RELEASE_CODE, 8'h00, 8'h00, 16'hF004);
        send_request(OP_RELEASE_CODE, 8'h00, 8'h00, 16'hE0FF);
        send_request(OP_SPARE_6, 8'h04, 8'h01, 16'h4004);
        send_request(OP_SPARE_7, 8'h05, 8'h02, 16'h8002);
        send_request(OP_RELEASE_ALL, 8'h00, 8'h00, 16'h0000);
        send_request(OP_RELEASE_ALL, 8'h00, 8'h00, 16'h0000);
        wait_for_reports();

        run_phase(0, 0, 220);
        run_phase(56, 0, 220);
        run_phase(0, 56, 220);
        run_phase(10, 10, 200);

        // The receiver holds off while requests keep coming, so the tracker must stall its input.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        for (int n = 0; n < 40; n++)
        begin
            send_random_request(counted);
        end
        wait_for_reports();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_hid_keyboard_report_tracker passed");
        else
            $display("tb_hid_keyboard_report_tracker failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/hkrt_pkg.sv
hdl/hkrt_core.sv
hdl/hid_keyboard_report_tracker.sv
tb/sv/hkrt_report_scoreboard.sv
tb/sv/tb_hid_keyboard_report_tracker.sv
